// ----- hw/rtl/base32_lowercase_encoder_macros.svh -----
// assertion macros used by the encoder checker
`ifndef BASE32_LOWERCASE_ENCODER_MACROS_SVH
`define BASE32_LOWERCASE_ENCODER_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define B32LE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is high
`define B32LE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/b32le_pkg.sv -----
// types, constants and the symbol alphabet of the base32 encoder
package b32le_pkg;

   localparam int unsigned SYM_W   = 5;
   localparam int unsigned LIMIT_W = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4096;

   // register index decoded from the byte address
   localparam logic REG_OUTPUT_LIMIT = 1'b0;

   localparam logic [6:0]       CHAR_A    = 7'd97;
   localparam logic [6:0]       CHAR_TWO  = 7'd50;
   localparam logic [SYM_W-1:0] ALPHA_LEN = 5'd26;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] symbol;
      logic       end_of_run;
   } rsp_type;

   // symbols cut from one byte plus the leftover bits for the next byte
   typedef struct packed {
      logic [2:0][SYM_W-1:0] syms;
      logic [1:0]            count;
      logic [3:0]            left_bits;
      logic [2:0]            left_count;
   } grp_type;

   function automatic logic [6:0] to_ascii(input logic [SYM_W-1:0] v);
      logic [6:0] r;
      if (v < ALPHA_LEN) begin
         r = CHAR_A + {2'b00, v};
      end else begin
         r = CHAR_TWO + {2'b00, v - ALPHA_LEN};
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/b32le_split.sv -----
// cuts one byte plus leftover bits into up to three 5-bit symbols
module b32le_split (
   input  logic [3:0]         pend_bits,
   input  logic [2:0]         pend_cnt,
   input  b32le_pkg::req_type req,
   output b32le_pkg::grp_type grp
);

   logic [2:0]  n;
   logic [11:0] wide;
   logic [11:0] aligned;
   logic [14:0] padded;
   logic [3:0]  total;
   logic [1:0]  full;
   logic [2:0]  rem;
   logic [4:0]  rem_mask;

   always_comb begin
      n = (pend_cnt > 3'd4) ? 3'd4 : pend_cnt;
      wide = {pend_bits, req.byte_in};
      // left-align the n+8 live bits; stale bits above them fall off the top
      aligned = wide << (3'd4 - n);
      padded = {aligned, 3'b000};
      total = {1'b0, n} + 4'd8;
      full = (total < 4'd10) ? 2'd1 : 2'd2;
      rem = (total < 4'd10) ? 3'(total - 4'd5) : 3'(total - 4'd10);
      rem_mask = (5'd1 << rem) - 5'd1;

      grp.syms[0] = padded[14:10];
      grp.syms[1] = padded[9:5];
      grp.syms[2] = padded[4:0];
      // zero-padded tail symbol on the final byte
      grp.count = (req.final_byte && rem != 3'd0) ? full + 2'd1 : full;
      if (req.final_byte) begin
         grp.left_bits = 4'd0;
         grp.left_count = 3'd0;
      end else begin
         grp.left_bits = wide[3:0] & rem_mask[3:0];
         grp.left_count = rem;
      end
   end

endmodule

// ----- hw/rtl/base32_lowercase_encoder.sv -----
// base32 lowercase encoder top level: byte intake, symbol drain, limit register
// path: a transferred byte's symbol group is registered, then each symbol passes through the output register
// throughput: one symbol per cycle at the output register while rsp_stall does not hold it;
// a byte yields 1 to 3 symbols, one drain step each, dropped ones included
// reset: synchronous, clears pending bits, counts and valids; limit returns to 4096
module base32_lowercase_encoder (
   input  logic               clock,
   input  logic               reset,
   // byte input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  b32le_pkg::req_type req_data,
   // symbol output channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b32le_pkg::rsp_type rsp_data,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // leftover message bits, updated at each byte transfer
   logic [3:0] pend_bits_ff, pend_bits_in;
   logic [2:0] pend_cnt_ff,  pend_cnt_in;

   // symbol group of the byte being drained
   b32le_pkg::grp_type grp_ff, grp_in;
   b32le_pkg::grp_type grp_new;
   logic               grp_valid_ff, grp_valid_in;
   logic               grp_fin_ff,   grp_fin_in;
   logic [1:0]         idx_ff,       idx_in;

   // symbols emitted so far in this message, and the limit register
   logic [b32le_pkg::LIMIT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic [b32le_pkg::LIMIT_W-1:0] limit_ff,    limit_in;
   logic [b32le_pkg::LIMIT_W-1:0] emit_next;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   b32le_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   logic req_fire;
   logic out_free;
   logic at_limit;
   logic is_last;
   logic step;
   logic emit;
   logic grp_done;
   logic csr_wr;
   logic [b32le_pkg::SYM_W-1:0] cur_sym;

   b32le_split u_split (
      .pend_bits (pend_bits_ff),
      .pend_cnt  (pend_cnt_ff),
      .req       (req_data),
      .grp       (grp_new)
   );

   // drain control: one symbol of the group per step, dropped ones need no output slot
   always_comb begin
      cur_sym = grp_ff.syms[idx_ff];
      at_limit = emit_cnt_ff >= limit_ff;
      is_last = idx_ff == (grp_ff.count - 2'd1);
      out_free = !rsp_valid_ff || !rsp_stall;
      step = grp_valid_ff && (at_limit || out_free);
      emit = step && !at_limit;
      grp_done = step && is_last;
      emit_next = emit_cnt_ff + 16'd1;
   end

   // a new byte enters in the same cycle the previous group's last symbol moves on
   assign req_stall = grp_valid_ff && !grp_done;
   assign req_fire = req_valid && !req_stall;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in = pend_cnt_ff;
      grp_in = grp_ff;
      grp_valid_in = grp_valid_ff;
      grp_fin_in = grp_fin_ff;
      idx_in = idx_ff;
      emit_cnt_in = emit_cnt_ff;
      limit_in = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (req_fire) begin
         pend_bits_in = grp_new.left_bits;
         pend_cnt_in = grp_new.left_count;
         grp_in = grp_new;
         grp_fin_in = req_data.final_byte;
         grp_valid_in = 1'b1;
         idx_in = 2'd0;
      end else if (grp_done) begin
         grp_valid_in = 1'b0;
      end else if (step) begin
         idx_in = idx_ff + 2'd1;
      end

      // message end clears the count whether or not its last symbol was dropped
      if (grp_done && grp_fin_ff) begin
         emit_cnt_in = '0;
      end else if (emit) begin
         emit_cnt_in = emit_next;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.symbol = b32le_pkg::to_ascii(cur_sym);
         rsp_data_in.end_of_run = (grp_fin_ff && is_last) || (emit_next == limit_ff);
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr && csr_paddr[2] == b32le_pkg::REG_OUTPUT_LIMIT) begin
         limit_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff <= '0;
         grp_valid_ff <= 1'b0;
         idx_ff <= '0;
         emit_cnt_ff <= '0;
         limit_ff <= b32le_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff <= pend_cnt_in;
         grp_valid_ff <= grp_valid_in;
         idx_ff <= idx_in;
         emit_cnt_ff <= emit_cnt_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      grp_fin_ff <= grp_fin_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // register readback, zero-wait transfers
   assign csr_prdata = (csr_paddr[2] == b32le_pkg::REG_OUTPUT_LIMIT) ?
                       {16'd0, limit_ff} : 32'd0;
   assign csr_pready = 1'b1;

endmodule

// ----- hw/rtl/b32le_checker.sv -----
// port-level checker for the base32 encoder, bound to the top level
`include "base32_lowercase_encoder_macros.svh"

module b32le_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input b32le_pkg::rsp_type rsp_data,
   input logic               csr_psel,
   input logic               csr_penable,
   input logic               csr_pwrite,
   input logic [2:0]         csr_paddr,
   input logic [31:0]        csr_pwdata,
   input logic [31:0]        csr_prdata,
   input logic               csr_pready
);

   logic               sym_ok;
   logic               rsp_wait;
   logic               rsp_held;
   logic               req_idle;
   logic               limit_sel;
   logic               limit_wr;
   logic               rdbk_ok;
   b32le_pkg::rsp_type rsp_prev_ff, rsp_prev_in;
   logic [15:0]        wdata_ff,    wdata_in;

   assign sym_ok = (rsp_data.symbol >= 7'd97 && rsp_data.symbol <= 7'd122) ||
                   (rsp_data.symbol >= 7'd50 && rsp_data.symbol <= 7'd55);

   assign rsp_prev_in = rsp_data;
   assign wdata_in = csr_pwdata[15:0];

   always_ff @(posedge clock) begin
      rsp_prev_ff <= rsp_prev_in;
      wdata_ff <= wdata_in;
   end

   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_held = rsp_valid && rsp_data == rsp_prev_ff;
   assign req_idle = !req_valid && !req_stall;
   assign limit_sel = csr_paddr[2] == b32le_pkg::REG_OUTPUT_LIMIT;
   assign limit_wr = csr_psel && csr_penable && csr_pwrite && csr_pready && limit_sel;
   assign rdbk_ok = !limit_sel || csr_prdata == {16'd0, wdata_ff};

   // every shown symbol is from the lowercase base32 alphabet
   `B32LE_ASSERT_NOW(a_sym_alphabet, clock, reset, rsp_valid, sym_ok, "symbol off alphabet")

   // a stalled result transfer holds
   `B32LE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_held, "held result changed")

   // a limit write reads back on the next cycle
   `B32LE_ASSERT_NEXT(a_limit_rdbk, clock, reset, limit_wr, rdbk_ok, "limit readback mismatch")

   // with no byte offered and nothing pending the encoder stays ready
   `B32LE_ASSERT_NEXT(a_idle_take, clock, reset, req_idle, !req_stall, "refused while idle")

endmodule

bind base32_lowercase_encoder b32le_checker u_b32le_checker (.*);
